>>> hw/rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int MAP_WORDS  = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 32;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORD_SHIFT = PAGE_SHIFT + $clog2(WORD_BITS);
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAP_CW     = $clog2(MAP_WORDS + 1);
  localparam int PAGE_IW    = MAP_AW + $clog2(WORD_BITS);
  localparam int THR_W      = 21;
  localparam int PAGE_CAP   = MAP_WORDS * WORD_BITS;

  localparam logic [THR_W-1:0] LOW_LIMIT_PAGE = THR_W'(32'h0008_0000 >> PAGE_SHIFT);
  localparam logic [THR_W-1:0] ONE_MIB_PAGE   = THR_W'((32'h400 * 32'h400) >> PAGE_SHIFT);
  localparam logic [31:0]      FAIL_ADDR      = 32'hFFFF_FFFF;

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_KERNEL_START = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_KERNEL_END   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MEM_HOLE     = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_PAGE_COUNT   = 2'd3;

  localparam logic REQ_INIT  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] scan_addr;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] page_addr;
  } rsp_t;

  typedef struct packed {
    logic load_init;
    logic load_alloc;
    logic fill;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic found;
    logic fail;
  } sts_t;

endpackage

>>> hw/rtl/bpfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bpfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer for map rebuild and allocation scan.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             req_type,
  input  bpfa_pkg::sts_t   sts,
  output bpfa_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == bpfa_pkg::REQ_INIT) begin
            cmd.load_init = 1'b1;
            state_next    = ST_FILL;
          end else begin
            cmd.load_alloc = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.fail) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

>>> hw/rtl/bpfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_datapath
// Config registers, free map RAM, word mask builder and scan pipeline.
// ----------------------------------------------------------------------------
module bpfa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [bpfa_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  input  bpfa_pkg::req_t                req,
  input  bpfa_pkg::cmd_t                cmd,
  output bpfa_pkg::sts_t                sts,
  output bpfa_pkg::rsp_t                result
);

  localparam int AW  = bpfa_pkg::MAP_AW;
  localparam int CW  = bpfa_pkg::MAP_CW;
  localparam int PIW = bpfa_pkg::PAGE_IW;
  localparam int TW  = bpfa_pkg::THR_W;

  // bits of the word at page index base whose page index is >= thr
  function automatic logic [31:0] ge_mask(input logic [TW-1:0] base,
                                          input logic [TW-1:0] thr);
    logic [TW-1:0] diff;
    begin
      diff = thr - base;
      if (thr <= base) begin
        ge_mask = '1;
      end else if (diff >= TW'(32)) begin
        ge_mask = '0;
      end else begin
        ge_mask = 32'hFFFF_FFFF << diff[4:0];
      end
    end
  endfunction

  logic [31:0] kernel_start;
  logic [31:0] kernel_end;
  logic [31:0] mem_hole;
  logic [15:0] page_count;

  logic [TW-1:0] thr_limit;
  logic [TW-1:0] thr_klo;
  logic [TW-1:0] thr_khi;
  logic [TW-1:0] thr_hole;

  logic          map_valid;
  logic [CW-1:0] wptr;
  logic          pend_v;
  logic [AW-1:0] pend_addr;
  logic          issue;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [31:0]   word;
  logic [31:0]   word_lo;
  logic [4:0]    bit_idx;
  logic [TW-1:0] base;
  logic [31:0]   fill_mask;
  logic [31:0]   grant_addr;
  logic          start_oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_start <= '0;
      kernel_end   <= '0;
      mem_hole     <= '0;
      page_count   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpfa_pkg::CFG_KERNEL_START: kernel_start <= cfg_data;
        bpfa_pkg::CFG_KERNEL_END:   kernel_end   <= cfg_data;
        bpfa_pkg::CFG_MEM_HOLE:     mem_hole     <= cfg_data;
        bpfa_pkg::CFG_PAGE_COUNT:   page_count   <= cfg_data[15:0];
      endcase
    end
  end

  // page index thresholds for the rebuild sweep
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      thr_limit <= (TW'(page_count) > TW'(bpfa_pkg::PAGE_CAP)) ?
                   TW'(bpfa_pkg::PAGE_CAP) : TW'(page_count);
      thr_klo   <= (kernel_start == '0) ? '0 :
                   TW'((kernel_start - 32'd1) >> bpfa_pkg::PAGE_SHIFT);
      thr_khi   <= TW'(kernel_end >> bpfa_pkg::PAGE_SHIFT) + TW'(1);
      thr_hole  <= (mem_hole == '0) ? '0 :
                   TW'((mem_hole - 32'd1) >> bpfa_pkg::PAGE_SHIFT);
    end
  end

  // map reads as all used until the first rebuild
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
    end else if (cmd.load_init) begin
      map_valid <= 1'b1;
    end
  end

  assign start_oob = 32'(req.scan_addr >> bpfa_pkg::WORD_SHIFT) >= 32'(bpfa_pkg::MAP_WORDS);
  assign issue     = (wptr < CW'(bpfa_pkg::MAP_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      pend_v <= 1'b0;
    end else if (cmd.load_init) begin
      wptr   <= '0;
      pend_v <= 1'b0;
    end else if (cmd.load_alloc) begin
      wptr   <= start_oob ? CW'(bpfa_pkg::MAP_WORDS) :
                CW'(req.scan_addr >> bpfa_pkg::WORD_SHIFT);
      pend_v <= 1'b0;
    end else if (cmd.fill) begin
      wptr   <= wptr + CW'(1);
    end else if (cmd.scan) begin
      pend_v <= issue;
      if (issue) begin
        wptr <= wptr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= wptr[AW-1:0];
  end

  assign base = TW'({wptr[AW-1:0], 5'b0_0000});
  assign fill_mask = ~ge_mask(base, thr_limit)
                   & ~(ge_mask(base, thr_klo) & ~ge_mask(base, thr_khi))
                   & (~ge_mask(base, bpfa_pkg::LOW_LIMIT_PAGE)
                      | (ge_mask(base, bpfa_pkg::ONE_MIB_PAGE)
                         & ~ge_mask(base, thr_hole)));

  assign word    = map_valid ? ram_rdata : '0;
  assign word_lo = word & (~word + 32'd1);

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < 32; b++) begin
      if (word_lo[b]) begin
        bit_idx = bit_idx | 5'(b);
      end
    end
  end

  assign grant_addr = {20'(PIW'({pend_addr, bit_idx})), 12'h000};

  assign sts.fill_last = (wptr == CW'(bpfa_pkg::MAP_WORDS - 1));
  assign sts.found     = pend_v && (word != '0);
  assign sts.fail      = !sts.found && !issue;

  assign ram_we    = cmd.fill || (cmd.scan && sts.found);
  assign ram_waddr = cmd.fill ? wptr[AW-1:0] : pend_addr;
  assign ram_wdata = cmd.fill ? fill_mask : (word & ~word_lo);

  bpfa_ram #(
    .WIDTH (32),
    .DEPTH (bpfa_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (wptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.fill && sts.fill_last) begin
      result.status    <= bpfa_pkg::STATUS_OK;
      result.page_addr <= '0;
    end else if (cmd.scan && sts.found) begin
      result.status    <= bpfa_pkg::STATUS_OK;
      result.page_addr <= grant_addr;
    end else if (cmd.scan && sts.fail) begin
      result.status    <= bpfa_pkg::STATUS_FULL;
      result.page_addr <= bpfa_pkg::FAIL_ADDR;
    end
  end

endmodule

>>> hw/rtl/bitmap_page_frame_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-page free map.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  request  | start, busy                | req (req_type, scan_addr)
//  result   | done (one-cycle strobe)    | result (status, page_addr)
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// Rebuild writes one map word per cycle.
// Allocate reads one map word per cycle from the start word through the first
// word with a free page.
// After reset the map reads as all used; no clearing pass is needed.
// busy is high from acceptance through the done cycle; results are not stalled.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bpfa_pkg::req_t               req,
  output logic                         done,
  output bpfa_pkg::rsp_t               result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpfa_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_data
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  bpfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule
